// File: src/bdasc_pkg.sv
package bdasc_pkg;

  localparam int DIGIT_BITS = 4;
  localparam int CHAR_BITS = 6;

  localparam logic [CHAR_BITS-1:0] ASCII_ZERO = 6'd48;
  localparam logic [DIGIT_BITS-1:0] DABBLE_LIMIT = 4'd5;
  localparam logic [DIGIT_BITS-1:0] DABBLE_ADD = 4'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONVERT,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic shift;
    logic emit;
    logic final_digit;
  } dp_cmd_t;

endpackage

// File: src/bdasc_ctrl.sv
module bdasc_ctrl #(
  parameter int VALUE_BITS = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  output bdasc_pkg::dp_cmd_t cmd
);

  localparam int NDIG = (VALUE_BITS * 30103) / 100000 + 1;
  localparam int CW = $clog2(VALUE_BITS);

  bdasc_pkg::state_t state, state_next;
  logic [CW-1:0] cnt, cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bdasc_pkg::ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    unique case (state)
      bdasc_pkg::ST_IDLE: begin
        if (start) begin
          state_next = bdasc_pkg::ST_CONVERT;
          cnt_next   = CW'(VALUE_BITS - 1);
        end
      end
      bdasc_pkg::ST_CONVERT: begin
        if (cnt == '0) begin
          state_next = bdasc_pkg::ST_EMIT;
          cnt_next   = CW'(NDIG - 1);
        end else begin
          cnt_next = cnt - 1'b1;
        end
      end
      bdasc_pkg::ST_EMIT: begin
        if (cnt == '0) begin
          state_next = bdasc_pkg::ST_IDLE;
        end else begin
          cnt_next = cnt - 1'b1;
        end
      end
      default: begin
        state_next = bdasc_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    unique case (state)
      bdasc_pkg::ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      bdasc_pkg::ST_CONVERT: begin
        cmd.shift = 1'b1;
      end
      bdasc_pkg::ST_EMIT: begin
        cmd.emit        = 1'b1;
        cmd.final_digit = (cnt == '0);
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  a_cmd_exclusive: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.shift, cmd.emit}))
    else $error("more than one datapath command at once");

  a_convert_to_emit: assert property (@(posedge clk) disable iff (rst)
    (state == bdasc_pkg::ST_CONVERT && cnt == '0)
      |=> (state == bdasc_pkg::ST_EMIT && cnt == CW'(NDIG - 1)))
    else $error("conversion did not hand over to digit output");

  a_emit_ends: assert property (@(posedge clk) disable iff (rst)
    (state == bdasc_pkg::ST_EMIT && cnt == '0) |=> !busy)
    else $error("block still busy after the final digit");

endmodule

// File: src/bdasc_dp.sv
module bdasc_dp #(
  parameter int VALUE_BITS = 32
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  bdasc_pkg::dp_cmd_t                    cmd,
  input  logic [31:0]                           value,
  output logic [bdasc_pkg::CHAR_BITS-1:0]       digit_char,
  output logic                                  last,
  output logic                                  strobe
);

  localparam int NDIG = (VALUE_BITS * 30103) / 100000 + 1;
  localparam int DB = bdasc_pkg::DIGIT_BITS;
  localparam int BW = NDIG * DB;

  logic [VALUE_BITS+31:0] value_ext;
  logic [VALUE_BITS-1:0]  shreg;
  logic [BW-1:0]          bcd;
  logic [BW-1:0]          bcd_adj;
  logic [DB-1:0]          top_digit;
  logic                   top_nonzero;
  logic                   seen;

  assign value_ext   = {{VALUE_BITS{1'b0}}, value};
  assign top_digit   = bcd[BW-1 -: DB];
  assign top_nonzero = (top_digit != '0);

  // Every digit of five or more gets three added before the shift, so that
  // the doubling carries correctly into the next decade.
  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      if (bcd[i*DB +: DB] >= bdasc_pkg::DABBLE_LIMIT) begin
        bcd_adj[i*DB +: DB] = bcd[i*DB +: DB] + bdasc_pkg::DABBLE_ADD;
      end else begin
        bcd_adj[i*DB +: DB] = bcd[i*DB +: DB];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      shreg <= value_ext[VALUE_BITS-1:0];
      bcd   <= '0;
    end else if (cmd.shift) begin
      shreg <= {shreg[VALUE_BITS-2:0], 1'b0};
      bcd   <= {bcd_adj[BW-2:0], shreg[VALUE_BITS-1]};
    end else if (cmd.emit) begin
      bcd <= {bcd[BW-DB-1:0], {DB{1'b0}}};
    end
    if (cmd.emit) begin
      digit_char <= bdasc_pkg::ASCII_ZERO + {2'b00, top_digit};
      last       <= cmd.final_digit;
    end
  end

  // Leading zeros are dropped until the first non-zero digit; the final
  // digit always goes out so that zero still gives one character.
  always_ff @(posedge clk) begin
    if (rst) begin
      seen   <= 1'b0;
      strobe <= 1'b0;
    end else begin
      strobe <= cmd.emit && (seen || top_nonzero || cmd.final_digit);
      if (cmd.load) begin
        seen <= 1'b0;
      end else if (cmd.emit && top_nonzero) begin
        seen <= 1'b1;
      end
    end
  end

  a_final_strobes: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit && cmd.final_digit) |=> (strobe && last))
    else $error("final digit was not output");

  a_no_gap: assert property (@(posedge clk) disable iff (rst)
    (strobe && !last) |=> strobe)
    else $error("gap inside a run of digits");

  a_run_ends: assert property (@(posedge clk) disable iff (rst)
    (strobe && last) |=> !strobe)
    else $error("digit output after the final digit");

endmodule

// File: src/binary_to_decimal_ascii.sv
// Channel  Handshake                 Ports
// -------  ------------------------  ---------------------
// input    start & !busy             value[31:0]
// output   strobe, one cycle each    digit_char[5:0], last
//
// A word is taken at an edge with start high and busy low; busy then stays
// high for VALUE_BITS + D cycles, D = floor(VALUE_BITS * 0.30103) + 1
// (42 cycles at the default width), after which a new word may be taken.
// The conversion shifts one bit per cycle; digits then leave one per cycle,
// each shown for one cycle behind strobe, leading zeros suppressed.
// Reset is synchronous and returns the controller to idle with no output.
// The receiver cannot stall the output.
module binary_to_decimal_ascii #(
  parameter int VALUE_BITS = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [31:0]                     value,
  output logic [bdasc_pkg::CHAR_BITS-1:0] digit_char,
  output logic                            last,
  output logic                            strobe
);

  bdasc_pkg::dp_cmd_t cmd;

  bdasc_ctrl #(
    .VALUE_BITS(VALUE_BITS)
  ) u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .busy (busy),
    .cmd  (cmd)
  );

  bdasc_dp #(
    .VALUE_BITS(VALUE_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .value     (value),
    .digit_char(digit_char),
    .last      (last),
    .strobe    (strobe)
  );

endmodule

// File: bench/tb_top.sv
module tb_top;

  localparam int RANDOM_WORDS = 208;

  typedef struct packed {
    logic [bdasc_pkg::CHAR_BITS-1:0] digit_char;
    logic                            last;
  } digit_word_t;

  class digit_scoreboard;
    digit_word_t pending_digits[$];
    int          mismatches = 0;
    int          words_sent = 0;
    int          digits_seen = 0;

    // Shift-and-add-3 over ten BCD nibbles, which is enough for any 32-bit word.
    function void note_value(logic [31:0] number);
      logic [39:0] bcd;
      digit_word_t exp_digit;
      logic [3:0] nibble;
      int top;
      bcd = '0;
      for (int b = 31; b >= 0; b--) begin
        for (int d = 0; d < 10; d++) begin
          if (bcd[d*4 +: 4] >= 4'd5) begin
            bcd[d*4 +: 4] = bcd[d*4 +: 4] + 4'd3;
          end
        end
        bcd = {bcd[38:0], number[b]};
      end
      top = 0;
      for (int d = 0; d < 10; d++) begin
        if (bcd[d*4 +: 4] != 4'd0) begin
          top = d;
        end
      end
      for (int d = top; d >= 0; d--) begin
        nibble = bcd[d*4 +: 4];
        if (nibble > 4'd9) begin
          nibble = 4'd0;
        end
        exp_digit.digit_char = bdasc_pkg::ASCII_ZERO + (bdasc_pkg::CHAR_BITS)'(nibble);
        exp_digit.last = (d == 0);
        pending_digits.push_back(exp_digit);
      end
      words_sent++;
    endfunction

    function void check_digit(logic [bdasc_pkg::CHAR_BITS-1:0] digit_char, logic last);
      digit_word_t exp_digit;
      digits_seen++;
      if (pending_digits.size() == 0) begin
        $display("%0t: unexpected digit: expected none, actual char %0d last %0b",
                 $time, digit_char, last);
        mismatches++;
      end else begin
        exp_digit = pending_digits.pop_front();
        if (digit_char !== exp_digit.digit_char) begin
          $display("%0t: digit_char mismatch: expected %0d, actual %0d",
                   $time, exp_digit.digit_char, digit_char);
          mismatches++;
        end
        if (last !== exp_digit.last) begin
          $display("%0t: last mismatch: expected %0b, actual %0b",
                   $time, exp_digit.last, last);
          mismatches++;
        end
      end
    endfunction

    function int pending();
      return pending_digits.size();
    endfunction
  endclass

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            start = 1'b0;
  logic [31:0]                     value = '0;
  logic                            busy;
  logic [bdasc_pkg::CHAR_BITS-1:0] digit_char;
  logic                            last;
  logic                            strobe;

  digit_scoreboard sb = new();

  binary_to_decimal_ascii i_dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .value      (value),
    .digit_char (digit_char),
    .last       (last),
    .strobe     (strobe)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && strobe) begin
      sb.check_digit(digit_char, last);
    end
  end

  function automatic longint power_of_ten(int k);
    longint p;
    p = 1;
    repeat (k) p = p * 10;
    return p;
  endfunction

  // Numbers of a chosen digit count in two picks of five, so that every output length turns up.
  function automatic logic [31:0] pick_value();
    int ndig;
    longint lo;
    longint hi;
    longint pick;
    case ($urandom_range(0, 4))
      0: begin
        return $urandom;
      end
      1: begin
        pick = power_of_ten($urandom_range(0, 9)) + $urandom_range(0, 2) - 1;
        return pick[31:0];
      end
      2: begin
        return $urandom_range(0, 99);
      end
      default: begin
        ndig = $urandom_range(1, 10);
        lo = (ndig == 1) ? 0 : power_of_ten(ndig - 1);
        hi = (ndig == 10) ? 64'hFFFF_FFFF : power_of_ten(ndig) - 1;
        return $urandom_range(hi[31:0], lo[31:0]);
      end
    endcase
  endfunction

  function automatic int pick_gap(int idx, int total);
    if (idx >= (total * 3) / 4) begin
      return 0;
    end
    if ($urandom_range(0, 2) == 0) begin
      return $urandom_range(1, 17);
    end
    return 0;
  endfunction

  // Holds start high until the block takes the word; start stays high into the
  // next word when there is no gap.
  task automatic drive_value(logic [31:0] number, int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    value <= number;
    do @(posedge clk); while (busy);
    sb.note_value(number);
  endtask

  initial begin
    logic [31:0] directed_words[$];
    directed_words = '{32'd0, 32'd1, 32'd5, 32'd9, 32'd10, 32'd19, 32'd99, 32'd100,
                       32'd4294967295, 32'd4294967294, 32'd1000000000, 32'd999999999,
                       32'd4000000000, 32'h8000_0000, 32'h7FFF_FFFF, 32'hAAAA_AAAA,
                       32'h5555_5555, 32'd1234567890, 32'd12345678, 32'd10000,
                       32'd90909, 32'd0};
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    foreach (directed_words[i]) begin
      drive_value(directed_words[i], (i % 4 == 3) ? $urandom_range(1, 17) : 0);
    end
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      drive_value(pick_value(), pick_gap(i, RANDOM_WORDS));
    end
    @(posedge clk);
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    $display("Converted %0d words (%0d directed, rest random) into %0d digits.",
             sb.words_sent, directed_words.size(), sb.digits_seen);
    $display("Output lengths of one to ten digits were exercised, with and without idle gaps.");
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("Timed out with %0d digits still awaited.", sb.pending());
    $display("end of test: mismatches");
    $finish;
  end

endmodule
